### hdl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Map geometry
    localparam int MAP_WORDS    = 32;
    localparam int WORD_BITS    = 16;
    localparam int TOTAL_BLOCKS = MAP_WORDS * WORD_BITS;

    // Field widths of the ports
    localparam int BLK_W    = 9;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int WIDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int IDX_W   = $clog2(TOTAL_BLOCKS);
    localparam int GRANT_W = (IDX_W > BLK_W) ? IDX_W : BLK_W;

    // Block number -> word index by reciprocal multiply, exact for BLK_W-bit inputs
    localparam int Q_SHIFT = BLK_W + BIT_W;
    localparam int RECIP   = ((2 ** Q_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W  = BLK_W + Q_SHIFT + 1;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    // Map port request from the controller
    typedef struct packed
    {
        logic                 rd_en;
        logic [WIDX_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [WIDX_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } map_req_t;

    // Position of the lowest set bit (0 when none)
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] low;
        logic [BIT_W-1:0]     idx;
        low = v & (~v + WORD_BITS'(1));
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (low[j])
            begin
                idx = idx | BIT_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

### hdl/bba_map_ram.sv
`timescale 1ns / 1ps

module bba_map_ram
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  map_req_t             req,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] data_reg;
    logic [MAP_WORDS-1:0] word_valid_reg;
    logic                 hit_reg;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
        end
    end

    // per-word written flags; an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                word_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= word_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

### hdl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// First-fit block allocator over a bitmap of MAP_WORDS words of WORD_BITS bits
// (bit j of word i is block i*WORD_BITS+j, set means in use; all free after
// reset, block 0 is reserved). One request is worked on at a time and each
// gives exactly one result transfer. An allocate walks the map from word 0,
// one word read per cycle from the single read port of the map memory, and
// looks at up to MAP_WORDS words before it finds a free bit or reports the
// map full. A free reads, modifies and writes its word; a free of block 0
// or of a block beyond the map touches no word and reports status 2. The
// result sits in an output register, so the next request is accepted while
// it waits.

module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [BLK_W-1:0]    block_number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BLK_W-1:0]    granted_block,
    output logic [STATUS_W-1:0] status
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RESP
    } state_t;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

    state_t               state_reg;
    logic [WIDX_W-1:0]    word_reg;
    logic [BLK_W-1:0]     blk_reg;
    status_t              res_status_reg;
    logic [BLK_W-1:0]     res_block_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [BLK_W-1:0]     out_block_reg;

    map_req_t             map_req;
    logic [WORD_BITS-1:0] map_data;

    logic                 in_xfer;
    logic                 free_bad;
    logic [PROD_W-1:0]    quot_prod;
    logic [WIDX_W-1:0]    free_word;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;
    logic [GRANT_W-1:0]   grant_full;
    logic [BLK_W-1:0]     word_base;
    logic [BLK_W-1:0]     rem_full;
    logic [BIT_W-1:0]     rem_bit;

    bba_map_ram u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (map_data)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Free request decode: range check and word index by reciprocal multiply
    assign free_bad  = (block_number == '0) || (32'(block_number) >= 32'(TOTAL_BLOCKS));
    assign quot_prod = PROD_W'(block_number) * PROD_W'(RECIP);
    assign free_word = WIDX_W'(quot_prod >> Q_SHIFT);

    // Scan: lowest free block of the word just read; block 0 never offered
    always_comb
    begin
        free_bits = ~map_data;
        if (word_reg == '0)
        begin
            free_bits[0] = 1'b0;
        end
    end

    assign found      = |free_bits;
    assign found_bit  = lowest_set(free_bits);
    assign grant_full = GRANT_W'(word_reg) * GRANT_W'(WORD_BITS) + GRANT_W'(found_bit);

    // Free: bit position within the word
    assign word_base = BLK_W'(word_reg) * BLK_W'(WORD_BITS);
    assign rem_full  = blk_reg - word_base;
    assign rem_bit   = rem_full[BIT_W-1:0];

    // Map port: each read is issued in the cycle before its word is checked
    always_comb
    begin
        map_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == OP_ALLOC)
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = '0;
                    end
                    else if (!free_bad)
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = free_word;
                    end
                end
            end
            S_SCAN:
            begin
                map_req.rd_en   = !found && (word_reg != LAST_WORD);
                map_req.rd_addr = word_reg + WIDX_W'(1);
                map_req.wr_en   = found;
                map_req.wr_addr = word_reg;
                map_req.wr_data = map_data | (WORD_BITS'(1) << found_bit);
            end
            S_FREE:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = word_reg;
                map_req.wr_data = map_data & ~(WORD_BITS'(1) << rem_bit);
            end
            S_RESP:
            begin
                map_req = '0;
            end
            default:
            begin
                map_req = '0;
            end
        endcase
    end

    // Control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            word_reg       <= '0;
            blk_reg        <= '0;
            res_status_reg <= STATUS_OK;
            res_block_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_block_reg  <= '0;
        end
        else
        begin
            // load from the response state, else clear on transfer
            if ((state_reg == S_RESP) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        blk_reg <= block_number;
                        if (operation == OP_ALLOC)
                        begin
                            word_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                        else if (free_bad)
                        begin
                            res_status_reg <= STATUS_BAD;
                            res_block_reg  <= '0;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            word_reg  <= free_word;
                            state_reg <= S_FREE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (found)
                    begin
                        res_status_reg <= STATUS_OK;
                        res_block_reg  <= grant_full[BLK_W-1:0];
                        state_reg      <= S_RESP;
                    end
                    else if (word_reg == LAST_WORD)
                    begin
                        res_status_reg <= STATUS_FULL;
                        res_block_reg  <= '0;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        word_reg <= word_reg + WIDX_W'(1);
                    end
                end
                S_FREE:
                begin
                    res_status_reg <= STATUS_OK;
                    res_block_reg  <= '0;
                    state_reg      <= S_RESP;
                end
                S_RESP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_status_reg <= res_status_reg;
                        out_block_reg  <= res_block_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_block = out_block_reg;
    assign status        = out_status_reg;

    // Errors and out-of-space never carry a block number
    a_no_block_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> granted_block == '0)
        else $error("block number given with error status");

    // Map is written only while scanning or freeing
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en |-> (state_reg == S_SCAN) || (state_reg == S_FREE))
        else $error("map write outside scan or free");

    // Reserved block 0 is never marked used
    a_block0_free: assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en && (map_req.wr_addr == '0) |-> map_req.wr_data[0] == 1'b0)
        else $error("reserved block 0 marked used");

    // A result is loaded only from the response state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result loaded outside response state");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the bitmap first-fit block allocator.
//
// One process offers requests (allocate or free), one process drives the
// result side's ready, and one process checks every result transfer against
// a queue of predicted grants. The grant predictor keeps its own copy of the
// usage map and is updated at the edge where a request transfer happens, so
// the queue always holds one grant per request still in flight.

module tb_top;

    import bba_pkg::*;

    localparam int CLK_HALF   = 4;    // 8 ns period
    localparam int DRAIN_WAIT = 40;   // a little over the worst allocate scan
    localparam int OPENING_N  = 25;

    // One predicted result
    typedef struct
    {
        logic [BLK_W-1:0] blk;
        status_t          st;
    } grant_t;

    // One directed request; the grant is typed in only where fixed is set
    typedef struct
    {
        op_t              op;
        logic [BLK_W-1:0] blk;
        bit               fixed;
        logic [BLK_W-1:0] want_blk;
        status_t          want_st;
    } opening_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                operation;
    logic [BLK_W-1:0]    block_number;
    logic                out_valid;
    logic                out_ready;
    logic [BLK_W-1:0]    granted_block;
    logic [STATUS_W-1:0] status;

    // Predictor state: one bit per block, set means handed out
    logic [WORD_BITS-1:0] used_map [MAP_WORDS];

    grant_t       pending_grants [$];
    opening_row_t opening_rows [OPENING_N];

    int error_count;
    int requests_sent;     // request transfers so far
    int grants_seen;       // result transfers so far
    int full_predicted;    // allocates predicted to find the map full

    bitmap_block_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .block_number  (block_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_block (granted_block),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Hard stop: far beyond the slowest legal run (up to 1225 requests, each a full
    // map scan plus random gaps on both sides, plus the long result hold-off).
    initial
    begin
        #5ms;
        $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Grant predictor. Allocate: lowest clear bit of the first word that
    // has one, block 0 never counts as free; a full map leaves everything
    // alone and answers out of space. Free: block 0 or a number past the
    // map is a bad request; otherwise the bit is cleared (already clear
    // is fine).
    // ------------------------------------------------------------------
    function automatic grant_t predict_grant(input op_t op, input logic [BLK_W-1:0] blk);
        grant_t               g;
        logic [WORD_BITS-1:0] avail;
        int                   w;
        int                   b;
        g.blk = '0;
        g.st  = STATUS_OK;
        if (op == OP_ALLOC)
        begin
            g.st = STATUS_FULL;
            for (w = 0; w < MAP_WORDS; w++)
            begin
                avail = ~used_map[w];
                if (w == 0)
                begin
                    avail[0] = 1'b0;
                end
                if (avail != '0)
                begin
                    b = 0;
                    while (!avail[b])
                    begin
                        b++;
                    end
                    used_map[w][b] = 1'b1;
                    g.blk = BLK_W'(w * WORD_BITS + b);
                    g.st  = STATUS_OK;
                    break;
                end
            end
        end
        else if (blk == '0 || int'(blk) >= TOTAL_BLOCKS)
        begin
            g.st = STATUS_BAD;
        end
        else
        begin
            used_map[int'(blk) / WORD_BITS][int'(blk) % WORD_BITS] = 1'b0;
        end
        return g;
    endfunction

    // Some block currently handed out, searched from a random start; 0 if none
    // (a free of 0 then just becomes a bad request).
    function automatic logic [BLK_W-1:0] pick_used_block();
        int start;
        int k;
        int n;
        start = $urandom_range(TOTAL_BLOCKS - 1, 1);
        for (k = 0; k < TOTAL_BLOCKS; k++)
        begin
            n = (start + k) % TOTAL_BLOCKS;
            if (n != 0 && used_map[n / WORD_BITS][n % WORD_BITS])
            begin
                return BLK_W'(n);
            end
        end
        return '0;
    endfunction

    // Sender is calm (no gaps) through a stretch of the random part
    function automatic bit sender_calm();
        return requests_sent >= 300 && requests_sent < 450;
    endfunction

    // Offer one request. Called at a falling edge, returns at the falling
    // edge after its transfer. Each falling edge carries at most one write
    // of in_valid, so a held-high valid is never dropped and re-raised.
    task automatic offer(input op_t op, input logic [BLK_W-1:0] blk, input bit fixed,
                         input logic [BLK_W-1:0] want_blk, input status_t want_st);
        grant_t g;
        while (!sender_calm() && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        block_number <= blk;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        // transfer happened at this edge: predict its grant now
        g = predict_grant(op, blk);
        if (g.st == STATUS_FULL)
        begin
            full_predicted++;
        end
        if (fixed)
        begin
            g.blk = want_blk;
            g.st  = want_st;
        end
        pending_grants.push_back(g);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic offer_checked(input op_t op, input logic [BLK_W-1:0] blk);
        offer(op, blk, 1'b0, '0, STATUS_OK);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : sender
        int n;
        int r;
        int guard;

        in_valid     = 1'b0;
        operation    = OP_ALLOC;
        block_number = '0;
        rst_n        = 1'b0;
        error_count    = 0;
        requests_sent  = 0;
        grants_seen    = 0;
        full_predicted = 0;
        for (n = 0; n < MAP_WORDS; n++)
        begin
            used_map[n] = '0;
        end

        // Directed opening. After reset the map is empty, so the first
        // allocates hand out 1, 2, 3; freeing 0 is rejected; freeing a
        // block twice is harmless; a freed low block is the next one handed
        // out. The run of allocates at the end crosses from word 0 to word 1.
        opening_rows = '{
            '{OP_ALLOC, 9'd0,   1'b1, 9'd1, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b1, 9'd2, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b1, 9'd3, STATUS_OK},
            '{OP_FREE,  9'd0,   1'b1, 9'd0, STATUS_BAD},
            '{OP_FREE,  9'd511, 1'b1, 9'd0, STATUS_OK},
            '{OP_FREE,  9'd2,   1'b1, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b1, 9'd2, STATUS_OK},
            '{OP_FREE,  9'd2,   1'b1, 9'd0, STATUS_OK},
            '{OP_FREE,  9'd2,   1'b1, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd511, 1'b1, 9'd2, STATUS_OK},
            '{OP_FREE,  9'd256, 1'b0, 9'd0, STATUS_OK},
            '{OP_FREE,  9'h0AA, 1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'h155, 1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK},
            '{OP_ALLOC, 9'd0,   1'b0, 9'd0, STATUS_OK}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < OPENING_N; n++)
        begin
            offer(opening_rows[n].op, opening_rows[n].blk, opening_rows[n].fixed,
                  opening_rows[n].want_blk, opening_rows[n].want_st);
        end

        // Mixed traffic: mostly allocates and frees of blocks really in use,
        // some frees of arbitrary numbers (block 0, blocks already free).
        for (n = 0; n < 250; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                offer_checked(OP_ALLOC, BLK_W'($urandom_range(TOTAL_BLOCKS - 1)));
            else if (r < 90)
                offer_checked(OP_FREE, pick_used_block());
            else
                offer_checked(OP_FREE, BLK_W'($urandom_range(511)));
        end

        // Fill: allocate-heavy until the map is full (block 511 is handed
        // out on the way) and a number of allocates have come back out of
        // space, with the odd free so full/not-full flips a few times.
        full_predicted = 0;
        guard = 0;
        while (full_predicted < 15 && guard < 700)
        begin
            if ($urandom_range(99) < 94)
                offer_checked(OP_ALLOC, BLK_W'($urandom_range(511)));
            else
                offer_checked(OP_FREE, pick_used_block());
            guard++;
        end

        // Drain: free-heavy, so holes open all over the map and allocates
        // have to scan past full words to find them.
        for (n = 0; n < 250; n++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                offer_checked(OP_FREE, pick_used_block());
            else if (r < 90)
                offer_checked(OP_ALLOC, BLK_W'($urandom_range(511)));
            else
                offer_checked(OP_FREE, BLK_W'($urandom_range(511)));
        end

        in_valid <= 1'b0;

        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        // nothing should trickle out after the last expected grant
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("** bitmap_block_allocator: PASSED **");
        else
            $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side ready. Random stalls, a calm stretch, and one long
    // hold-off while the sender keeps offering: the output register fills,
    // the block finishes the request behind it, and then in_ready drops.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && grants_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (grants_seen >= 400 && grants_seen < 560)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 19);
        end
    end

    // ------------------------------------------------------------------
    // Grant checker: every result transfer against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && out_valid && out_ready)
        begin
            grants_seen++;
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result transfer: granted_block %0d status %0d",
                         $realtime, granted_block, status);
                error_count++;
            end
            else
            begin
                g = pending_grants.pop_front();
                if (granted_block !== g.blk)
                begin
                    $display("%0t: granted_block expected %0d got %0d",
                             $realtime, g.blk, granted_block);
                    error_count++;
                end
                if (status !== g.st)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, g.st, status);
                    error_count++;
                end
            end
        end
    end

endmodule

### filelist.f
hdl/bba_pkg.sv
hdl/bba_map_ram.sv
hdl/bitmap_block_allocator.sv
tb/sv/tb_top.sv
